// File: hw/rtl/ohd_pkg.sv
// Shared types, constants and helpers of the obstacle mask dilation block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package ohd_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_RADIUS  = 31;
   localparam int STORE_DEPTH = MAX_RADIUS * (MAX_WIDTH + 1) + 1;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int SLOT_W  = $clog2(STORE_DEPTH + 1);
   localparam int AGE_W   = SLOT_W + 1;
   localparam int DIST_W  = 7;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int QDEPTH  = 4;
   localparam int OQ_DEPTH = 2;

   localparam logic [DIST_W-1:0] SAT_DIST = 7'd127;

   localparam int HUE_SCALE     = 43;
   localparam int HUE_OFF_GREEN = 85;
   localparam int HUE_OFF_BLUE  = 171;
   localparam int SAT_SCALE     = 255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_HUE_LIMIT    = 3'd2,
      CSR_SAT_LIMIT    = 3'd3,
      CSR_RADIUS       = 3'd4
   } ohd_csr_type;

   typedef struct packed {
      logic       drain;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       mark;
   } ohd_item_type;

   typedef struct packed {
      logic [COL_W:0]      width;
      logic [ROW_W:0]      height;
      logic [RAD_W-1:0]    radius;
      logic [SLOT_W-1:0]   delay;
   } ohd_cfg_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       end_of_frame;
   } ohd_out_type;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_WRITE = 10'b0000000100,
      ST_COLRD = 10'b0000001000,
      ST_COLWR = 10'b0000010000,
      ST_AGE   = 10'b0000100000,
      ST_SLOT  = 10'b0001000000,
      ST_MARK  = 10'b0010000000,
      ST_POP   = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } ohd_state_type;

   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] d);
      sat_inc = (d >= SAT_DIST) ? SAT_DIST : d + 7'd1;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ohd_front.sv
// Front end: takes input words, runs the hue and saturation test and
// queues classified words for the back end. Depends on ohd_pkg.
`default_nettype none
module ohd_front
   import ohd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic         opcode,
   input  wire logic [7:0]   blue,
   input  wire logic [7:0]   green,
   input  wire logic [7:0]   red,
   input  wire logic [7:0]   hue_limit,
   input  wire logic [7:0]   sat_limit,
   input  wire logic         clear_busy,
   output logic              item_valid,
   output ohd_item_type      item,
   input  wire logic         item_take
);

   localparam int QP_W = $clog2(QDEPTH);
   localparam int QC_W = $clog2(QDEPTH + 1) + 1;

   logic                    sa_valid_ff, sa_valid_in;
   ohd_item_type            sa_item_ff, sa_item_in;
   logic                    sa_ok_ff, sa_ok_in;
   logic signed [8:0]       sa_n_ff, sa_n_in;
   logic signed [9:0]       sa_kk_ff, sa_kk_in;
   logic                    sa_strict_ff, sa_strict_in;
   logic [7:0]              sa_d_ff, sa_d_in;
   logic [7:0]              sa_mx_ff, sa_mx_in;

   ohd_item_type            q_mem [QDEPTH];
   logic [QP_W-1:0]         q_wr_ff, q_wr_in, q_rd_ff, q_rd_in;
   logic [QC_W-1:0]         q_cnt_ff, q_cnt_in;

   logic                    accept;
   logic [7:0]              mx, mn;
   logic signed [9:0]       k;
   logic signed [18:0]      n_ext, kk_ext, d_ext, hue_lhs, hue_rhs;
   logic [15:0]             sat_lhs, sat_rhs;
   logic                    hue_ok, mark;
   ohd_item_type            q_wd;

   // hold off while the back end clears its column store
   assign full   = clear_busy || ((q_cnt_ff + QC_W'(sa_valid_ff)) >= QC_W'(QDEPTH));
   assign accept = push && !full;

   always_comb begin
      mx = (red > green) ? ((red > blue) ? red : blue) : ((green > blue) ? green : blue);
      mn = (red < green) ? ((red < blue) ? red : blue) : ((green < blue) ? green : blue);
      sa_d_in  = mx - mn;
      sa_mx_in = mx;
      sa_ok_in = (blue != 8'd0) && (green != 8'd0) && (red != 8'd0) && (mx != mn);
      if (mx == red) begin
         sa_n_in = $signed({1'b0, green}) - $signed({1'b0, blue});
         k       = $signed({2'b00, hue_limit});
      end else if (mx == green) begin
         sa_n_in = $signed({1'b0, blue}) - $signed({1'b0, red});
         k       = $signed({2'b00, hue_limit}) - 10'sd85;
      end else begin
         sa_n_in = $signed({1'b0, red}) - $signed({1'b0, green});
         k       = $signed({2'b00, hue_limit}) - 10'sd171;
      end
      // trunc(q) < k  is  q < k for k > 0, and q <= k-1 otherwise
      sa_strict_in = (k > 10'sd0);
      sa_kk_in     = sa_strict_in ? k : k - 10'sd1;
      sa_item_in.drain = opcode;
      sa_item_in.blue  = blue;
      sa_item_in.green = green;
      sa_item_in.red   = red;
      sa_item_in.mark  = 1'b0;
      sa_valid_in      = accept;
   end

   always_comb begin
      n_ext   = 19'(sa_n_ff);
      kk_ext  = 19'(sa_kk_ff);
      d_ext   = $signed({11'b0, sa_d_ff});
      hue_lhs = n_ext * 19'(HUE_SCALE);
      hue_rhs = kk_ext * d_ext;
      hue_ok  = sa_strict_ff ? (hue_lhs < hue_rhs) : (hue_lhs <= hue_rhs);
      sat_lhs = 16'(SAT_SCALE) * {8'b0, sa_d_ff};
      sat_rhs = {8'b0, sat_limit} * {8'b0, sa_mx_ff};
      mark    = sa_ok_ff && hue_ok && (sat_lhs > sat_rhs) && !sa_item_ff.drain;
      q_wd      = sa_item_ff;
      q_wd.mark = mark;
   end

   always_comb begin
      q_wr_in  = sa_valid_ff ? q_wr_ff + QP_W'(1) : q_wr_ff;
      q_rd_in  = item_take ? q_rd_ff + QP_W'(1) : q_rd_ff;
      q_cnt_in = q_cnt_ff + QC_W'(sa_valid_ff) - QC_W'(item_take);
   end

   assign item_valid = (q_cnt_ff != '0);
   assign item       = q_mem[q_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
         q_wr_ff     <= '0;
         q_rd_ff     <= '0;
         q_cnt_ff    <= '0;
      end else begin
         sa_valid_ff <= sa_valid_in;
         q_wr_ff     <= q_wr_in;
         q_rd_ff     <= q_rd_in;
         q_cnt_ff    <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_item_ff   <= sa_item_in;
      sa_ok_ff     <= sa_ok_in;
      sa_n_ff      <= sa_n_in;
      sa_kk_ff     <= sa_kk_in;
      sa_strict_ff <= sa_strict_in;
      sa_d_ff      <= sa_d_in;
      sa_mx_ff     <= sa_mx_in;
      if (sa_valid_ff) begin
         q_mem[q_wr_ff] <= q_wd;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ohd_back.sv
// Back end: raster tracking, separable dilation over the column store,
// pixel delay line and result queue. Depends on ohd_pkg.
`default_nettype none
module ohd_back
   import ohd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ohd_cfg_type  cfg,
   input  wire logic         item_valid,
   input  wire ohd_item_type item,
   output logic              item_take,
   output logic              clear_busy,
   output logic              out_empty,
   input  wire logic         out_pop,
   output ohd_out_type       out_word
);

   localparam int OP_W = $clog2(OQ_DEPTH);
   localparam int OC_W = $clog2(OQ_DEPTH + 1);
   localparam logic [AGE_W-1:0] DEPTH_A = AGE_W'(STORE_DEPTH);

   logic [24:0]        pix_mem  [STORE_DEPTH];
   logic               mask_mem [STORE_DEPTH];
   logic [DIST_W-1:0]  col_mem  [MAX_WIDTH];

   ohd_state_type      state_ff, state_in;
   ohd_item_type       item_ff, item_in;
   logic [SLOT_W-1:0]  wr_slot_ff, wr_slot_in, rd_slot_ff, rd_slot_in;
   logic [SLOT_W-1:0]  fill_ff, fill_in;
   logic [COL_W-1:0]   in_col_ff, in_col_in;
   logic [ROW_W-1:0]   in_row_ff, in_row_in;
   logic [DIST_W-1:0]  row_dist_ff, row_dist_in;
   logic [COL_W-1:0]   ci_ff, ci_in, c_ff, c_in, c_end_ff, c_end_in;
   logic [ROW_W-1:0]   ri_ff, ri_in;
   logic [SLOT_W-1:0]  newest_ff, newest_in, age_ff, age_in, slot_ff, slot_in;
   logic               last_row_ff, last_row_in;
   logic [RAD_W-1:0]   k_ff, k_in;
   logic [DIST_W-1:0]  newdist_ff, newdist_in;
   logic [COL_W-1:0]   clr_ff, clr_in;
   logic [24:0]        pix_rd_ff;
   logic               mask_rd_ff;
   logic [DIST_W-1:0]  col_rd_ff;

   ohd_out_type        oq_mem [OQ_DEPTH];
   logic [OP_W-1:0]    oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [OC_W-1:0]    oq_cnt_ff, oq_cnt_in;

   logic               pix_we, pix_re, mask_we, mask_wd, col_we, col_re, oq_push, oq_pop;
   logic [24:0]        pix_wd;
   logic [SLOT_W-1:0]  mask_addr;
   logic [COL_W-1:0]   col_addr, diff;
   logic [DIST_W-1:0]  col_wd, newd;
   logic               last_col, last_row_ge, in_frame, end_row, col_ge_rad, ri_ge_rad;
   logic               hd, pop_go;
   logic [AGE_W-1:0]   age_wide, slot_sum;
   ohd_out_type        oq_wd;

   assign clear_busy = (state_ff == ST_CLEAR);
   assign diff       = ci_ff - c_ff;
   assign ri_ge_rad  = (ri_ff >= ROW_W'(cfg.radius));
   assign last_col    = ({1'b0, in_col_ff} + (COL_W+1)'(1)) >= cfg.width;
   assign last_row_ge = ({1'b0, in_row_ff} + (ROW_W+1)'(1)) >= cfg.height;
   assign in_frame    = ({1'b0, in_col_ff} < cfg.width) && ({1'b0, in_row_ff} < cfg.height);
   assign end_row     = ({1'b0, in_col_ff} + (COL_W+1)'(1)) == cfg.width;
   assign col_ge_rad  = (in_col_ff >= COL_W'(cfg.radius));
   assign hd       = ((COL_W+1)'(row_dist_ff)) <= ({1'b0, diff} + (COL_W+1)'(cfg.radius));
   assign newd     = hd ? '0 : ((ri_ff == '0) ? SAT_DIST : sat_inc(col_rd_ff));
   assign pop_go   = item_ff.drain || (fill_ff > cfg.delay);
   assign age_wide = AGE_W'(k_ff) * AGE_W'(cfg.width) + AGE_W'(diff);
   assign slot_sum = {1'b0, slot_ff} + AGE_W'(cfg.width);
   assign pix_wd   = {last_col && last_row_ge, item_ff.red, item_ff.green, item_ff.blue};
   assign mask_addr = (state_ff == ST_WRITE) ? wr_slot_ff : slot_ff;
   assign col_addr  = (state_ff == ST_CLEAR) ? clr_ff : c_ff;

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      wr_slot_in  = wr_slot_ff;
      rd_slot_in  = rd_slot_ff;
      fill_in     = fill_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      row_dist_in = row_dist_ff;
      ci_in       = ci_ff;
      ri_in       = ri_ff;
      c_in        = c_ff;
      c_end_in    = c_end_ff;
      newest_in   = newest_ff;
      last_row_in = last_row_ff;
      k_in        = k_ff;
      newdist_in  = newdist_ff;
      age_in      = age_ff;
      slot_in     = slot_ff;
      clr_in      = clr_ff;
      item_take   = 1'b0;
      pix_we      = 1'b0;
      pix_re      = 1'b0;
      mask_we     = 1'b0;
      mask_wd     = 1'b0;
      col_we      = 1'b0;
      col_re      = 1'b0;
      col_wd      = SAT_DIST;
      oq_push     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            col_we = 1'b1;
            clr_in = clr_ff + COL_W'(1);
            if (clr_ff == COL_W'(MAX_WIDTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               item_in   = item;
               if (!item.drain) begin
                  state_in = ST_WRITE;
               end else if (fill_ff != '0 && in_row_ff == '0 && in_col_ff == '0) begin
                  state_in = ST_POP;
               end
            end
         end
         ST_WRITE: begin
            pix_we     = 1'b1;
            mask_we    = 1'b1;
            newest_in  = wr_slot_ff;
            wr_slot_in = (wr_slot_ff == SLOT_W'(STORE_DEPTH - 1)) ? '0 : wr_slot_ff + SLOT_W'(1);
            fill_in    = fill_ff + SLOT_W'(1);
            if (item_ff.mark) begin
               row_dist_in = '0;
            end else if (in_col_ff == '0) begin
               row_dist_in = SAT_DIST;
            end else begin
               row_dist_in = sat_inc(row_dist_ff);
            end
            ci_in       = in_col_ff;
            ri_in       = in_row_ff;
            last_row_in = ({1'b0, in_row_ff} + (ROW_W+1)'(1)) == cfg.height;
            if (last_col) begin
               in_col_in = '0;
               in_row_in = last_row_ge ? '0 : in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            // finish the column that left the window, or the row tail
            if (in_frame && (end_row || col_ge_rad)) begin
               c_in     = col_ge_rad ? in_col_ff - COL_W'(cfg.radius) : '0;
               c_end_in = end_row ? in_col_ff : in_col_ff - COL_W'(cfg.radius);
               state_in = ST_COLRD;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_COLRD: begin
            col_re   = 1'b1;
            state_in = ST_COLWR;
         end
         ST_COLWR: begin
            col_we     = 1'b1;
            col_wd     = newd;
            newdist_in = newd;
            if (last_row_ff) begin
               k_in     = ri_ge_rad ? cfg.radius : ri_ff[RAD_W-1:0];
               state_in = ST_AGE;
            end else if (ri_ge_rad) begin
               k_in     = cfg.radius;
               state_in = ST_AGE;
            end else if (c_ff == c_end_ff) begin
               state_in = ST_POP;
            end else begin
               c_in     = c_ff + COL_W'(1);
               state_in = ST_COLRD;
            end
         end
         ST_AGE: begin
            age_in   = age_wide[SLOT_W-1:0];
            state_in = ST_SLOT;
         end
         ST_SLOT: begin
            if (newest_ff >= age_ff) begin
               slot_in = newest_ff - age_ff;
            end else begin
               slot_in = SLOT_W'({1'b0, newest_ff} + DEPTH_A - {1'b0, age_ff});
            end
            state_in = ST_MARK;
         end
         ST_MARK: begin
            if (newdist_ff <= (DIST_W'(k_ff) + DIST_W'(cfg.radius))) begin
               mask_we = 1'b1;
               mask_wd = 1'b1;
            end
            if (last_row_ff && k_ff != '0) begin
               k_in    = k_ff - RAD_W'(1);
               slot_in = (slot_sum >= DEPTH_A) ? SLOT_W'(slot_sum - DEPTH_A)
                                                : slot_sum[SLOT_W-1:0];
            end else if (c_ff == c_end_ff) begin
               state_in = ST_POP;
            end else begin
               c_in     = c_ff + COL_W'(1);
               state_in = ST_COLRD;
            end
         end
         ST_POP: begin
            if (!pop_go) begin
               state_in = ST_IDLE;
            end else if (oq_cnt_ff < OC_W'(OQ_DEPTH)) begin
               pix_re     = 1'b1;
               rd_slot_in = (rd_slot_ff == SLOT_W'(STORE_DEPTH - 1)) ? '0
                                                                    : rd_slot_ff + SLOT_W'(1);
               fill_in    = fill_ff - SLOT_W'(1);
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            oq_push  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result queue
   assign oq_pop    = out_pop && (oq_cnt_ff != '0);
   assign out_empty = (oq_cnt_ff == '0);
   assign out_word  = oq_mem[oq_rd_ff];
   always_comb begin
      oq_wd.blue         = mask_rd_ff ? 8'd0 : pix_rd_ff[7:0];
      oq_wd.green        = mask_rd_ff ? 8'd0 : pix_rd_ff[15:8];
      oq_wd.red          = mask_rd_ff ? 8'd0 : pix_rd_ff[23:16];
      oq_wd.end_of_frame = pix_rd_ff[24];
      oq_wr_in  = oq_push ? oq_wr_ff + OP_W'(1) : oq_wr_ff;
      oq_rd_in  = oq_pop ? oq_rd_ff + OP_W'(1) : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + OC_W'(oq_push) - OC_W'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         wr_slot_ff  <= '0;
         rd_slot_ff  <= '0;
         fill_ff     <= '0;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         row_dist_ff <= SAT_DIST;
         clr_ff      <= '0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_cnt_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         wr_slot_ff  <= wr_slot_in;
         rd_slot_ff  <= rd_slot_in;
         fill_ff     <= fill_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         row_dist_ff <= row_dist_in;
         clr_ff      <= clr_in;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_cnt_ff   <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ci_ff       <= ci_in;
      ri_ff       <= ri_in;
      c_ff        <= c_in;
      c_end_ff    <= c_end_in;
      newest_ff   <= newest_in;
      last_row_ff <= last_row_in;
      k_ff        <= k_in;
      newdist_ff  <= newdist_in;
      age_ff      <= age_in;
      slot_ff     <= slot_in;
      if (oq_push) begin
         oq_mem[oq_wr_ff] <= oq_wd;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[wr_slot_ff] <= pix_wd;
      end
      if (mask_we) begin
         mask_mem[mask_addr] <= mask_wd;
      end
      if (pix_re) begin
         pix_rd_ff  <= pix_mem[rd_slot_ff];
         mask_rd_ff <= mask_mem[rd_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_addr] <= col_wd;
      end
      if (col_re) begin
         col_rd_ff <= col_mem[c_ff];
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= SLOT_W'(STORE_DEPTH))
      else $error("delay line fill above its depth");

   a_out_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> $past(state_ff) == ST_POP)
      else $error("result pushed without a delay line read");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP && pop_go) |-> fill_ff != '0)
      else $error("read from an empty delay line");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> slot_ff < SLOT_W'(STORE_DEPTH))
      else $error("mask slot outside the delay line");

endmodule
`default_nettype wire

// File: hw/rtl/hsv_obstacle_mask_dilate.sv
// Top level of the obstacle mask dilation block: configuration registers,
// front classifier and back dilation engine. Depends on ohd_pkg, ohd_front, ohd_back.
`default_nettype none
// Obstacle masking on a raster pixel stream. Each pixel word is tested for a
// red obstacle color (all channels nonzero, integer hue below hue_limit,
// saturation above sat_limit); marks are dilated by a square of half size
// radius and every pixel under the dilated mark leaves as black. Results come
// out in raster order, radius*image_width + radius pixel words after their
// input; drain words (opcode 1) given at the start of a frame flush the tail.
// Timing: the front classifies one word per cycle while req_full is low and
// queues it, after its classify register, in a four-deep queue; the back
// sequencer takes one word at a time and sets the rate. In the back a pixel
// word that finishes no column goes through take, delay line write, delay
// line read and result push. Finishing a column in the first radius rows adds
// a column store read and write; finishing one in a later row also adds two
// address steps and one mask write. At a row end every further finished
// column adds these steps the same way, and in the last row of a frame every
// finished column takes the longer path plus one more mask write per extra
// mask row, up to radius more. When no result leaves, the delay line read and
// result push drop out. A drain word goes through take, delay line read and
// result push, or only the take when it flushes nothing. After reset the
// 1024-entry column store is cleared, one entry a cycle, and req_full stays high meanwhile.
// Configuration writes land at once; write them only while no word is in flight.
module hsv_obstacle_mask_dilate
   import ohd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic                   req_opcode,
   input  wire logic [7:0]             req_blue,
   input  wire logic [7:0]             req_green,
   input  wire logic [7:0]             req_red,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [7:0]                  rsp_out_blue,
   output logic [7:0]                  rsp_out_green,
   output logic [7:0]                  rsp_out_red,
   output logic                        rsp_end_of_frame,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [10:0]       width_ff, width_in;
   logic [10:0]       height_ff, height_in;
   logic [7:0]        hue_ff, hue_in;
   logic [7:0]        sat_ff, sat_in;
   logic [4:0]        radius_ff, radius_in;
   logic [SLOT_W-1:0] delay_ff, delay_in;

   ohd_cfg_type       cfg;
   logic [AGE_W-1:0]  delay_wide;
   logic              clear_busy, item_valid, item_take;
   ohd_item_type      item;
   ohd_out_type       out_word;

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      hue_in    = hue_ff;
      sat_in    = sat_ff;
      radius_in = radius_ff;
      if (csr_write) begin
         unique case (ohd_csr_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            CSR_HUE_LIMIT:    hue_in    = csr_wdata[7:0];
            CSR_SAT_LIMIT:    sat_in    = csr_wdata[7:0];
            CSR_RADIUS:       radius_in = csr_wdata[4:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // clamp sizes: zero counts as one, oversize counts as the maximum
   always_comb begin
      if (width_ff == '0) begin
         cfg.width = (COL_W+1)'(1);
      end else if (width_ff > 11'(MAX_WIDTH)) begin
         cfg.width = (COL_W+1)'(MAX_WIDTH);
      end else begin
         cfg.width = (COL_W+1)'(width_ff);
      end
      if (height_ff == '0) begin
         cfg.height = (ROW_W+1)'(1);
      end else if (height_ff > 11'(MAX_HEIGHT)) begin
         cfg.height = (ROW_W+1)'(MAX_HEIGHT);
      end else begin
         cfg.height = (ROW_W+1)'(height_ff);
      end
      cfg.radius = (radius_ff > 5'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_ff);
      cfg.delay  = delay_ff;
      delay_wide = AGE_W'(cfg.radius) * AGE_W'(cfg.width) + AGE_W'(cfg.radius);
      delay_in   = delay_wide[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
         hue_ff    <= 8'd25;
         sat_ff    <= 8'd100;
         radius_ff <= 5'd30;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         radius_ff <= radius_in;
      end
   end

   // delay is registered from the clamped size and follows it in the next cycle
   always_ff @(posedge clock) begin
      delay_ff <= delay_in;
   end

   ohd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .opcode     (req_opcode),
      .blue       (req_blue),
      .green      (req_green),
      .red        (req_red),
      .hue_limit  (hue_ff),
      .sat_limit  (sat_ff),
      .clear_busy (clear_busy),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   ohd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .clear_busy (clear_busy),
      .out_empty  (rsp_empty),
      .out_pop    (rsp_pop),
      .out_word   (out_word)
   );

   assign rsp_out_blue     = out_word.blue;
   assign rsp_out_green    = out_word.green;
   assign rsp_out_red      = out_word.red;
   assign rsp_end_of_frame = out_word.end_of_frame;

endmodule
`default_nettype wire
